### design/brd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types, constants and helpers of the bit-pair response decoder.
// ----------------------------------------------------------------------------
package brd_pkg;

   // Character position count saturates here
   localparam int POSITION_LIMIT = 127;
   localparam int POS_W          = $clog2(POSITION_LIMIT + 1);

   localparam int NUM_COUNTERS   = 11;
   localparam int IDX_W          = 4;
   localparam int VALUE_W        = 16;
   localparam int DIGIT_CNT_W    = 3;
   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(NUM_COUNTERS - 1);

   localparam int FIELD_START      = 3;
   localparam int FIELD_LEN        = 4;
   localparam int LATE_FIELD_START = 59;
   localparam int STATUS_START     = 3;
   localparam int STATUS_LEN       = 2;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1500;

   // Request modes
   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // Result kinds and error codes
   localparam logic [1:0] KIND_COUNTER = 2'd0;
   localparam logic [1:0] KIND_STATUS  = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;
   localparam logic       ERR_TIMEOUT  = 1'b0;
   localparam logic       ERR_LINE     = 1'b1;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_REG_TIMEOUT = '0;

   // Event queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      EV_TIMEOUT,
      EV_BAD_LINE,
      EV_STATUS,
      EV_DUMP
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic           tray;
      logic           tank;
   } line_event_type;

   typedef enum logic {
      BK_IDLE,
      BK_DUMP
   } back_state_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] raw_byte;
      logic       expect_status;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [IDX_W-1:0]   counter_index;
      logic [VALUE_W-1:0] counter_value;
      logic               field_valid;
      logic               tray_present;
      logic               tank_needs_fill;
      logic               error_code;
      logic               last;
   } rsp_payload_type;

   typedef logic [NUM_COUNTERS-1:0][VALUE_W-1:0]     counter_bank_type;
   typedef logic [NUM_COUNTERS-1:0][DIGIT_CNT_W-1:0] digit_bank_type;

   // Returns {is_hex, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] res;
      res = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         res = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         res = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return res;
   endfunction

   function automatic logic [POS_W-1:0] field_start(input int i);
      logic [POS_W-1:0] s;
      if (i < NUM_COUNTERS - 1) begin
         s = POS_W'(FIELD_START + FIELD_LEN * i);
      end else begin
         s = POS_W'(LATE_FIELD_START);
      end
      return s;
   endfunction

endpackage
`default_nettype wire

### design/brd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brd_queue
// Short event queue that decouples the line parser from the result sequencer.
// ----------------------------------------------------------------------------
module brd_queue
   import brd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  line_event_type      push_item,
   output logic                full,
   input  wire logic           pop,
   output line_event_type      pop_item,
   output logic                empty
);

   line_event_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("event queue count out of range");
`endif

endmodule
`default_nettype wire

### design/brd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brd_front
// Request side: assembles characters from bit pairs, parses hex fields on the
// fly, tracks the timeout and posts one event per finished response.
// ----------------------------------------------------------------------------
module brd_front
   import brd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_push,
   output logic                req_full,
   input  req_payload_type     req_item,
   input  wire logic [15:0]    timeout_limit,
   output logic                ev_push,
   output line_event_type      ev_item,
   input  wire logic           ev_full,
   input  wire logic           dump_done,
   output counter_bank_type    counters,
   output digit_bank_type      digits
);

   logic                    receiving_ff, receiving_in;
   logic                    status_exp_ff, status_exp_in;
   logic [1:0]              pair_ff, pair_in;
   logic [5:0]              partial_ff, partial_in;
   logic                    prev_cr_ff, prev_cr_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [15:0]             tcount_ff, tcount_in;
   counter_bank_type        counter_ff, counter_in;
   digit_bank_type          digit_ff, digit_in;
   logic [7:0]              status_ff, status_in;
   logic [1:0]              sdigit_ff, sdigit_in;
   logic                    lock_ff, lock_in;

   logic                    accept;
   logic [1:0]              bits;
   logic [7:0]              ch;
   logic [4:0]              hex;
   logic [POS_W-1:0]        start;
   logic [POS_W-1:0]        offset;

   // Hold off new requests while the queue is full or a dump is still reading
   // the counter bank.
   assign req_full = ev_full || lock_ff;
   assign accept   = req_push && !req_full;
   assign bits     = {req_item.raw_byte[5], req_item.raw_byte[2]};
   assign ch       = {bits, partial_ff};
   assign hex      = hex_decode(ch);
   assign counters = counter_ff;
   assign digits   = digit_ff;

   always_comb begin
      receiving_in  = receiving_ff;
      status_exp_in = status_exp_ff;
      pair_in       = pair_ff;
      partial_in    = partial_ff;
      prev_cr_in    = prev_cr_ff;
      pos_in        = pos_ff;
      tcount_in     = tcount_ff;
      counter_in    = counter_ff;
      digit_in      = digit_ff;
      status_in     = status_ff;
      sdigit_in     = sdigit_ff;
      lock_in       = lock_ff && !dump_done;
      ev_push       = 1'b0;
      ev_item       = '{kind: EV_TIMEOUT, tray: 1'b0, tank: 1'b0};
      start         = '0;
      offset        = '0;

      if (accept && req_item.mode == MODE_CLEAR) begin
         receiving_in  = 1'b1;
         status_exp_in = req_item.expect_status;
         pair_in       = '0;
         partial_in    = '0;
         prev_cr_in    = 1'b0;
         pos_in        = '0;
         tcount_in     = '0;
         counter_in    = '0;
         digit_in      = '0;
         status_in     = '0;
         sdigit_in     = '0;
      end else if (accept && receiving_ff &&
                   (req_item.mode == MODE_BYTE || req_item.mode == MODE_TICK)) begin
         if (tcount_ff >= timeout_limit) begin
            receiving_in = 1'b0;
            ev_push      = 1'b1;
         end else begin
            tcount_in = 16'(tcount_ff + 1'b1);
            if (req_item.mode == MODE_BYTE) begin
               if (pair_ff != 2'd3) begin
                  // shift the pair in from the top, lowest pair ends at bit 0
                  partial_in = {bits, partial_ff[5:2]};
                  pair_in    = 2'(pair_ff + 1'b1);
               end else begin
                  pair_in    = '0;
                  partial_in = '0;
                  for (int i = 0; i < NUM_COUNTERS; i++) begin
                     start  = field_start(i);
                     offset = POS_W'(pos_ff - start);
                     if (pos_ff >= start && pos_ff < POS_W'(start + FIELD_LEN) && hex[4] &&
                         digit_ff[i] == DIGIT_CNT_W'(offset[1:0])) begin
                        counter_in[i] = {counter_ff[i][VALUE_W-5:0], hex[3:0]};
                        digit_in[i]   = DIGIT_CNT_W'(digit_ff[i] + 1'b1);
                     end
                  end
                  if (pos_ff >= POS_W'(STATUS_START) &&
                      pos_ff < POS_W'(STATUS_START + STATUS_LEN) && hex[4] &&
                      sdigit_ff == 2'(pos_ff - POS_W'(STATUS_START))) begin
                     status_in = {status_ff[3:0], hex[3:0]};
                     sdigit_in = 2'(sdigit_ff + 1'b1);
                  end
                  if (ch == CHAR_LF && prev_cr_ff) begin
                     // line end: a line feed never touches the parsed fields
                     receiving_in = 1'b0;
                     ev_push      = 1'b1;
                     if (pos_ff == POS_W'(1)) begin
                        ev_item.kind = EV_BAD_LINE;
                     end else if (status_exp_ff) begin
                        if (sdigit_ff != 2'(STATUS_LEN)) begin
                           ev_item.kind = EV_BAD_LINE;
                        end else begin
                           ev_item.kind = EV_STATUS;
                           ev_item.tray = status_ff[4];
                           ev_item.tank = status_ff[5];
                        end
                     end else begin
                        ev_item.kind = EV_DUMP;
                        lock_in      = 1'b1;
                     end
                  end else begin
                     prev_cr_in = (ch == CHAR_CR);
                     if (pos_ff < POS_W'(POSITION_LIMIT)) begin
                        pos_in = POS_W'(pos_ff + 1'b1);
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff  <= 1'b0;
         status_exp_ff <= 1'b0;
         pair_ff       <= '0;
         partial_ff    <= '0;
         prev_cr_ff    <= 1'b0;
         pos_ff        <= '0;
         tcount_ff     <= '0;
         counter_ff    <= '0;
         digit_ff      <= '0;
         status_ff     <= '0;
         sdigit_ff     <= '0;
         lock_ff       <= 1'b0;
      end else begin
         receiving_ff  <= receiving_in;
         status_exp_ff <= status_exp_in;
         pair_ff       <= pair_in;
         partial_ff    <= partial_in;
         prev_cr_ff    <= prev_cr_in;
         pos_ff        <= pos_in;
         tcount_ff     <= tcount_in;
         counter_ff    <= counter_in;
         digit_ff      <= digit_in;
         status_ff     <= status_in;
         sdigit_ff     <= sdigit_in;
         lock_ff       <= lock_in;
      end
   end

endmodule
`default_nettype wire

### design/brd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brd_back
// Result side: expands queued events into results and holds the current
// result in an output register.
// ----------------------------------------------------------------------------
module brd_back
   import brd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           ev_empty,
   input  line_event_type      ev_item,
   output logic                ev_pop,
   input  counter_bank_type    counters,
   input  digit_bank_type      digits,
   output logic                rsp_empty,
   input  wire logic           rsp_pop,
   output rsp_payload_type     rsp_item,
   output logic                dump_done
);

   back_state_type          state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_payload_type         out_ff, out_in;
   logic                    advance;
   logic                    load;

   function automatic rsp_payload_type counter_result(input counter_bank_type cb,
                                                      input digit_bank_type db,
                                                      input logic [IDX_W-1:0] i);
      rsp_payload_type r;
      logic            ok;
      r               = '0;
      ok              = (db[i] == DIGIT_CNT_W'(FIELD_LEN));
      r.result_kind   = KIND_COUNTER;
      r.counter_index = i;
      r.counter_value = ok ? cb[i] : '0;
      r.field_valid   = ok;
      r.last          = (i == LAST_INDEX);
      return r;
   endfunction

   assign advance   = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;
   assign dump_done = out_valid_ff && rsp_pop && out_ff.last &&
                      out_ff.result_kind == KIND_COUNTER;

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         BK_IDLE: begin
            if (advance && !ev_empty && ev_item.kind == EV_DUMP) begin
               state_in = BK_DUMP;
               idx_in   = IDX_W'(1);
            end
         end
         BK_DUMP: begin
            if (advance) begin
               if (idx_ff == LAST_INDEX) begin
                  state_in = BK_IDLE;
                  idx_in   = '0;
               end else begin
                  idx_in = IDX_W'(idx_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   // outputs
   always_comb begin
      ev_pop = 1'b0;
      load   = 1'b0;
      out_in = out_ff;
      case (state_ff)
         BK_IDLE: begin
            if (advance && !ev_empty) begin
               ev_pop = 1'b1;
               load   = 1'b1;
               out_in = '0;
               out_in.last = 1'b1;
               case (ev_item.kind)
                  EV_TIMEOUT: begin
                     out_in.result_kind = KIND_ERROR;
                     out_in.error_code  = ERR_TIMEOUT;
                  end
                  EV_BAD_LINE: begin
                     out_in.result_kind = KIND_ERROR;
                     out_in.error_code  = ERR_LINE;
                  end
                  EV_STATUS: begin
                     out_in.result_kind     = KIND_STATUS;
                     out_in.tray_present    = ev_item.tray;
                     out_in.tank_needs_fill = ev_item.tank;
                  end
                  EV_DUMP: begin
                     out_in = counter_result(counters, digits, '0);
                  end
                  default: begin
                     out_in.result_kind = KIND_ERROR;
                  end
               endcase
            end
         end
         BK_DUMP: begin
            if (advance) begin
               load   = 1'b1;
               out_in = counter_result(counters, digits, idx_ff);
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
      out_valid_in = load ? 1'b1 : (advance ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

`ifndef ASSERT_OFF
   a_dump_shows_counter: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DUMP |-> out_valid_ff && out_ff.result_kind == KIND_COUNTER &&
                              !out_ff.last)
      else $error("dump in progress without a pending counter result");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.result_kind != KIND_COUNTER |-> out_ff.last)
      else $error("status or error result not marked last");

   a_dump_continues: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_pop && out_ff.result_kind == KIND_COUNTER && !out_ff.last
      |=> out_valid_ff && out_ff.result_kind == KIND_COUNTER &&
          out_ff.counter_index == IDX_W'($past(out_ff.counter_index) + 1'b1))
      else $error("counter dump broke its sequence");
`endif

endmodule
`default_nettype wire

### design/bitpair_response_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitpair_response_decoder
// Decodes a response line sent two bits per raw UART byte into counter,
// status or error results.
// ----------------------------------------------------------------------------
// A request is taken whenever req_full is low. A clear request
// starts a response; raw bytes and ticks then count against timeout_limit.
// Four raw bytes make one character (bit 2 low, bit 5 high of each pair, least
// significant pair first) and the line ends at the first CR LF. At line end a
// counter dump yields eleven results, on consecutive cycles while rsp_pop is
// held high; a status reply or an error yields one. Results leave through an
// output register and a two-entry event queue sits between parser and
// sequencer, so the parser keeps taking requests while results wait, until
// two more finished lines sit queued behind the result on the ports. The
// exception is a counter dump: from its line end until its last result is
// popped req_full stays high, since the dump reads the live counter bank.
// ----------------------------------------------------------------------------
module bitpair_response_decoder
   import brd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request queue side
   input  wire logic                   req_push,
   output logic                        req_full,
   input  req_payload_type             req_item,
   // result queue side
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output rsp_payload_type             rsp_item,
   // register port
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]       prdata,
   output logic                        pready
);

   logic [15:0]       limit_ff, limit_in;
   logic              csr_hit;
   logic              ev_push, ev_full, ev_pop, ev_empty, dump_done;
   line_event_type    ev_in_item, ev_out_item;
   counter_bank_type  counters;
   digit_bank_type    digits;

   // Register decode: one 16-bit register, word aligned
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == CSR_REG_TIMEOUT);
   assign prdata  = csr_hit ? CSR_DATA_W'(limit_ff) : '0;

   always_comb begin
      limit_in = limit_ff;
      // write on the access phase, ignore unused addresses
      if (psel && penable && pwrite && pready && csr_hit) begin
         limit_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TIMEOUT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Parser: assemble characters, parse fields, post line events
   brd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_item      (req_item),
      .timeout_limit (limit_ff),
      .ev_push       (ev_push),
      .ev_item       (ev_in_item),
      .ev_full       (ev_full),
      .dump_done     (dump_done),
      .counters      (counters),
      .digits        (digits)
   );

   // Decouple parser from sequencer
   brd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_item (ev_in_item),
      .full      (ev_full),
      .pop       (ev_pop),
      .pop_item  (ev_out_item),
      .empty     (ev_empty)
   );

   // Sequencer: expand events into results, hold the result for the consumer
   brd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ev_empty  (ev_empty),
      .ev_item   (ev_out_item),
      .ev_pop    (ev_pop),
      .counters  (counters),
      .digits    (digits),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .dump_done (dump_done)
   );

endmodule
`default_nettype wire

### sim/decode_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// decode_scoreboard_pkg
// Line decoder prediction and result checking for the bit-pair response bench.
// ----------------------------------------------------------------------------
package decode_scoreboard_pkg;
   import brd_pkg::*;

   localparam int MAX_REPORTS = 40;

   class decode_scoreboard;
      logic [15:0]        timeout_limit;
      bit                 receiving;
      bit                 status_expected;
      bit [1:0]           pair_index;
      bit [5:0]           partial_char;
      bit                 previous_was_cr;
      bit [POS_W-1:0]     char_position;
      bit [15:0]          timeout_count;
      bit [VALUE_W-1:0]   counter_bank [NUM_COUNTERS];
      bit [DIGIT_CNT_W-1:0] digits_seen [NUM_COUNTERS];
      bit [7:0]           status_byte;
      bit [1:0]           status_digits;
      rsp_payload_type    pending_results [$];
      int                 mismatches;
      int                 compared;
      int                 effective_requests;
      int                 dumps;
      int                 statuses;
      int                 line_errors;
      int                 timeouts;

      function new();
         timeout_limit = TIMEOUT_RESET;
         restart(1'b0);
         receiving = 1'b0;
      endfunction

      static function bit nibble_of(input logic [7:0] c, output logic [3:0] nib);
         nib = '0;
         if (c >= "0" && c <= "9") begin
            nib = 4'(c - "0");
            return 1'b1;
         end
         if (c >= "a" && c <= "f") begin
            nib = 4'(c - "a" + 8'd10);
            return 1'b1;
         end
         if (c >= "A" && c <= "F") begin
            nib = 4'(c - "A" + 8'd10);
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void restart(input bit want_status);
         receiving       = 1'b1;
         status_expected = want_status;
         pair_index      = '0;
         partial_char    = '0;
         previous_was_cr = 1'b0;
         char_position   = '0;
         timeout_count   = '0;
         status_byte     = '0;
         status_digits   = '0;
         foreach (counter_bank[i]) begin
            counter_bank[i] = '0;
            digits_seen[i]  = '0;
         end
      endfunction

      function int lines_closed();
         return dumps + statuses + line_errors + timeouts;
      endfunction

      function void add_result(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                               input logic [VALUE_W-1:0] value, input logic valid,
                               input logic tray, input logic tank, input logic err,
                               input logic is_last);
         rsp_payload_type r;
         r.result_kind     = kind;
         r.counter_index   = idx;
         r.counter_value   = value;
         r.field_valid     = valid;
         r.tray_present    = tray;
         r.tank_needs_fill = tank;
         r.error_code      = err;
         r.last            = is_last;
         pending_results.push_back(r);
      endfunction

      // shift one decoded character into whichever fields cover its position
      function void take_char(input int p, input logic [7:0] ch);
         logic [3:0] nib;
         bit         ok;
         int         start;
         ok = nibble_of(ch, nib);
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            start = (i < NUM_COUNTERS - 1) ? FIELD_START + FIELD_LEN * i : LATE_FIELD_START;
            if (ok && p >= start && p < start + FIELD_LEN && digits_seen[i] == p - start) begin
               counter_bank[i] = {counter_bank[i][VALUE_W-5:0], nib};
               digits_seen[i]++;
            end
         end
         if (ok && p >= STATUS_START && p < STATUS_START + STATUS_LEN &&
             status_digits == p - STATUS_START) begin
            status_byte = {status_byte[3:0], nib};
            status_digits++;
         end
      endfunction

      function void close_line(input int p);
         bit ok;
         receiving = 1'b0;
         if (p == 1 || (status_expected && status_digits != STATUS_LEN)) begin
            add_result(KIND_ERROR, '0, '0, 1'b0, 1'b0, 1'b0, ERR_LINE, 1'b1);
            line_errors++;
            return;
         end
         if (status_expected) begin
            add_result(KIND_STATUS, '0, '0, 1'b0, status_byte[4], status_byte[5], 1'b0, 1'b1);
            statuses++;
            return;
         end
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            ok = (digits_seen[i] == FIELD_LEN);
            add_result(KIND_COUNTER, IDX_W'(i), ok ? counter_bank[i] : '0, ok, 1'b0, 1'b0,
                       1'b0, IDX_W'(i) == LAST_INDEX);
         end
         dumps++;
      endfunction

      function void note_request(input req_payload_type r);
         logic [1:0] bits;
         logic [7:0] ch;
         int         p;
         if (r.mode == MODE_CLEAR) begin
            restart(r.expect_status);
            effective_requests++;
            return;
         end
         if ((r.mode != MODE_BYTE && r.mode != MODE_TICK) || !receiving) return;
         effective_requests++;
         if (timeout_count >= timeout_limit) begin
            receiving = 1'b0;
            add_result(KIND_ERROR, '0, '0, 1'b0, 1'b0, 1'b0, ERR_TIMEOUT, 1'b1);
            timeouts++;
            return;
         end
         timeout_count++;
         if (r.mode == MODE_TICK) return;
         bits = {r.raw_byte[5], r.raw_byte[2]};
         if (pair_index < 3) begin
            if (pair_index == 0) partial_char = '0;
            partial_char[2*pair_index +: 2] = bits;
            pair_index++;
            return;
         end
         ch = {bits, partial_char};
         pair_index   = '0;
         partial_char = '0;
         p = char_position;
         take_char(p, ch);
         if (ch == CHAR_LF && previous_was_cr) begin
            close_line(p);
            return;
         end
         previous_was_cr = (ch == CHAR_CR);
         if (char_position < POSITION_LIMIT) char_position++;
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", what);
      endtask

      task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
         if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      compared, name, got, want));
      endtask

      task check_result(input rsp_payload_type got);
         rsp_payload_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: kind %0d index %0d",
                                      got.result_kind, got.counter_index));
            return;
         end
         want = pending_results.pop_front();
         compared++;
         compare_field("result_kind", got.result_kind, want.result_kind);
         compare_field("counter_index", got.counter_index, want.counter_index);
         compare_field("counter_value", got.counter_value, want.counter_value);
         compare_field("field_valid", got.field_valid, want.field_valid);
         compare_field("tray_present", got.tray_present, want.tray_present);
         compare_field("tank_needs_fill", got.tank_needs_fill, want.tank_needs_fill);
         compare_field("error_code", got.error_code, want.error_code);
         compare_field("last", got.last, want.last);
      endtask
   endclass

endpackage

### sim/bitpair_response_decoder_tb.sv
// ----------------------------------------------------------------------------
// bitpair_response_decoder_tb
// Drives response lines, two bits per raw byte, through the decoder and checks
// every counter, status and error result against a running line predictor.
// ----------------------------------------------------------------------------
module bitpair_response_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import brd_pkg::*;
   import decode_scoreboard_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 4;
   // output register, two-entry event queue and an eleven-result dump
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 600000;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] TIMEOUT_ADDR = {CSR_REG_TIMEOUT, 2'b00};

   // receiver behaviors, switched whenever pop_window wraps to zero
   localparam logic [1:0] POP_EAGER    = 2'd0;
   localparam logic [1:0] POP_COIN     = 2'd1;
   localparam logic [1:0] POP_SLUGGISH = 2'd2;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_push  = 1'b0;
   logic                  req_full;
   req_payload_type       req_item  = '0;
   logic                  rsp_empty;
   logic                  rsp_pop   = 1'b0;
   rsp_payload_type       rsp_item;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   decode_scoreboard board = new();

   // sender pacing
   int         burst_left = 0;
   bit         steady     = 1'b0;
   int         tick_pct   = 0;
   int         limit_writes = 0;
   logic [7:0] text_buf [$];

   // receiver pacing
   logic [1:0] pop_style  = POP_EAGER;
   logic [5:0] pop_window = '0;
   int         stall_left = 0;
   int         cycle_count = 0;

   bitpair_response_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d results pending",
                  cycle_count, board.pending_results.size());
         $display("bitpair_response_decoder verification failed");
         $finish;
      end
   end

   // Stall the result side on a pattern of its own: eager, coin flip, or long
   // stalls with a single pop between them.
   always @(posedge clock) begin
      pop_window <= pop_window + 1'b1;
      if (pop_window == '0) pop_style <= 2'($urandom_range(0, 2));
      case (pop_style)
         POP_EAGER: rsp_pop <= 1'b1;
         POP_COIN:  rsp_pop <= 1'($urandom);
         default: begin
            if (stall_left == 0) begin
               rsp_pop    <= 1'b1;
               stall_left <= $urandom_range(1, 12);
            end else begin
               rsp_pop    <= 1'b0;
               stall_left <= stall_left - 1;
            end
         end
      endcase
   end

   // Check each result accepted at this edge against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) board.check_result(rsp_item);
   end

   // Push one request; the sender works in bursts with random gaps unless
   // the current line is sent steady. Hold push high into the next request.
   task automatic push_request(input logic [1:0] mode, input logic [7:0] raw,
                               input logic want_status);
      req_payload_type item;
      int              gap;
      item.mode          = mode;
      item.raw_byte      = raw;
      item.expect_status = want_status;
      if (burst_left == 0 && !steady) begin
         gap = $urandom_range(1, 6);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_push <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request(item);
   endtask

   // Drop push, wait for every predicted result, then let the block go quiet.
   task automatic settle();
      req_push <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Read timeout_limit back and compare it with the predictor's copy.
   task automatic check_limit_readback();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= TIMEOUT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[15:0] !== board.timeout_limit)
         board.report_mismatch($sformatf("timeout_limit reads %0h, expected %0h",
                                         prdata[15:0], board.timeout_limit));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Only called while idle: after reset or after settle(). The readback
   // that follows drops pwrite.
   task automatic write_limit(input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= TIMEOUT_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.timeout_limit = value;
      limit_writes++;
      check_limit_readback();
   endtask

   // Split a character into four raw bytes, bit 2 low and bit 5 high of each
   // pair, with random noise on the other bits and random ticks in between.
   task automatic send_char(input logic [7:0] ch);
      logic [7:0] raw;
      for (int k = 0; k < 4; k++) begin
         if (tick_pct > 0 && $urandom_range(1, 100) <= tick_pct)
            push_request(MODE_TICK, 8'($urandom), 1'($urandom));
         raw    = 8'($urandom);
         raw[2] = ch[2*k];
         raw[5] = ch[2*k+1];
         push_request(MODE_BYTE, raw, 1'($urandom));
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_buffer();
      foreach (text_buf[i]) send_char(text_buf[i]);
   endtask

   task automatic end_line();
      send_char(CHAR_CR);
      send_char(CHAR_LF);
   endtask

   task automatic start_response(input logic want_status);
      push_request(MODE_CLEAR, 8'($urandom), want_status);
   endtask

   function automatic logic [7:0] hex_char();
      string digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   // Half the time take a character right next to a hex range.
   function automatic logic [7:0] non_hex_char();
      logic [7:0] near_miss [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};
      logic [7:0] c;
      logic [3:0] nib;
      if ($urandom_range(0, 1) == 0) return near_miss[$urandom_range(0, 5)];
      do c = 8'($urandom);
      while (decode_scoreboard::nibble_of(c, nib) || c == CHAR_CR || c == CHAR_LF);
      return c;
   endfunction

   function automatic logic [7:0] filler_char();
      return ($urandom_range(0, 1) == 0) ? hex_char() : non_hex_char();
   endfunction

   // Build a line body: hex digits on the field positions of a counter dump
   // or of a status reply, spoiled at flaw_pct percent, filler elsewhere.
   task automatic compose_line(input bit counters, input int flaw_pct, input int length);
      bit in_field;
      text_buf.delete();
      for (int p = 0; p < length; p++) begin
         if (counters)
            in_field = (p >= FIELD_START && p < FIELD_START + FIELD_LEN * (NUM_COUNTERS - 1)) ||
                       (p >= LATE_FIELD_START && p < LATE_FIELD_START + FIELD_LEN);
         else
            in_field = (p >= STATUS_START && p < STATUS_START + STATUS_LEN);
         if (in_field && $urandom_range(1, 100) > flaw_pct) text_buf.push_back(hex_char());
         else if (in_field) text_buf.push_back(non_hex_char());
         else text_buf.push_back(filler_char());
      end
   endtask

   task automatic run_directed();
      tick_pct = 0;
      // requests while idle, and the unused mode, are all dropped
      push_request(MODE_BYTE, 8'hFF, 1'b1);
      push_request(MODE_TICK, 8'h00, 1'b0);
      push_request(MODE_UNUSED, 8'hA5, 1'b1);
      // empty line
      start_response(1'b0);
      end_line();
      // status replies: both flags, tank only, bad digit, too short
      start_response(1'b1);
      send_text("ok:30");
      end_line();
      start_response(1'b1);
      send_text("ok:2Fxy");
      end_line();
      start_response(1'b1);
      send_text("ok:3g");
      end_line();
      start_response(1'b1);
      send_text("ok");
      end_line();
      // full dump with extreme values and mixed case
      start_response(1'b0);
      send_text("#C FFFF0000ffffaBcD1234567890AbCdEf9999abcd----------------FfFf");
      end_line();
      // short dump: first field complete, second cut off
      start_response(1'b0);
      send_text("xx:12345");
      end_line();
      // stray CR and stray LF must not end the line
      start_response(1'b0);
      send_char(CHAR_CR);
      send_char("x");
      send_char(CHAR_LF);
      send_text("5");
      end_line();
      // clear mid-character restarts the response
      start_response(1'b0);
      send_text("zz:12");
      push_request(MODE_BYTE, 8'h24, 1'b0);
      push_request(MODE_UNUSED, 8'h00, 1'b0);
      push_request(MODE_BYTE, 8'hDB, 1'b1);
      start_response(1'b1);
      send_text("QQ:1F");
      end_line();
      settle();

      // smallest limit: second byte or second tick times out
      write_limit(16'd1);
      start_response(1'b0);
      push_request(MODE_BYTE, 8'h00, 1'b0);
      push_request(MODE_BYTE, 8'hFF, 1'b0);
      start_response(1'b1);
      push_request(MODE_TICK, 8'h00, 1'b0);
      push_request(MODE_TICK, 8'h00, 1'b0);
      settle();
      // CR LF takes eight bytes: just in time at eight, timeout wins at seven
      write_limit(16'd8);
      start_response(1'b0);
      end_line();
      settle();
      write_limit(16'd7);
      start_response(1'b1);
      end_line();
      settle();
   endtask

   // Random lines: mostly well-formed dumps and status replies with random
   // content, plus empty lines, loose requests and abandoned lines.
   task automatic run_random_phase(input int item_goal, input int line_goal);
      int   first_items;
      int   first_lines;
      int   pick;
      int   length;
      logic want_status;
      first_items = board.effective_requests;
      first_lines = board.lines_closed();
      while (board.effective_requests - first_items < item_goal ||
             board.lines_closed() - first_lines < line_goal) begin
         steady   = ($urandom_range(0, 3) == 0);
         tick_pct = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
         pick     = $urandom_range(0, 99);
         if (pick < 40) begin
            want_status = ($urandom_range(0, 6) != 0);
            length = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 9);
            start_response(want_status);
            compose_line(1'b0, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(5, 40), length);
            send_buffer();
            end_line();
         end else if (pick < 62) begin
            // mostly short dumps with cut-off fields, now and then a full one
            want_status = ($urandom_range(0, 6) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 3) length = $urandom_range(63, 66);
            else length = $urandom_range(1, 24);
            start_response(want_status);
            compose_line(1'b1, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10), length);
            send_buffer();
            end_line();
         end else if (pick < 72) begin
            start_response(1'($urandom));
            end_line();
         end else if (pick < 82) begin
            repeat ($urandom_range(1, 6))
               push_request(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
         end else begin
            // abandon a line part way, often mid-character; the next clear restarts
            start_response(1'($urandom));
            compose_line(1'($urandom), 5, $urandom_range(1, 20));
            send_buffer();
            repeat ($urandom_range(0, 3)) push_request(MODE_BYTE, 8'($urandom), 1'($urandom));
         end
         // now and then hold off until every result has drained
         if ($urandom_range(0, 19) == 0) settle();
      end
      steady   = 1'b0;
      tick_pct = 0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      check_limit_readback();
      run_directed();

      // widest limit: nothing times out
      write_limit(16'hFFFF);
      run_random_phase(20, 1);
      settle();
      // tight limit: dumps and slow replies run out of time
      write_limit(16'($urandom_range(30, 300)));
      run_random_phase(20, 1);
      settle();
      write_limit(TIMEOUT_RESET);
      run_random_phase(20, 1);
      settle();

      $display("Covered %0d counted requests across %0d timeout_limit settings, %0d results.",
               board.effective_requests, limit_writes, board.compared);
      $display("Lines closed: %0d counter dumps, %0d status replies, %0d bad lines, %0d timeouts.",
               board.dumps, board.statuses, board.line_errors, board.timeouts);
      if (board.mismatches == 0 && board.pending_results.size() == 0) begin
         $display("bitpair_response_decoder verification clean");
      end else begin
         $display("%0d mismatches, %0d results still pending",
                  board.mismatches, board.pending_results.size());
         $display("bitpair_response_decoder verification failed");
      end
      $finish;
   end

endmodule
